// ----- hw/rtl/assert_macros.svh -----
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mpq_pkg.sv -----
`timescale 1ns / 1ps
package mpq_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1024;
  localparam int unsigned TLEN_W         = 11;
  localparam int unsigned POS_W          = 10;
  localparam int unsigned KEY_W          = 8;
  localparam logic [TLEN_W-1:0] TLEN_RST = 11'd1024;

  localparam logic [31:0] MIX_INIT   = 32'h7FED7FED;
  localparam logic [31:0] CARRY_INIT = 32'hEEEEEEEE;

  // crypt table seed recurrence
  localparam int unsigned SEED_W     = 22;
  localparam logic [SEED_W-1:0] SEED_INIT = 22'h100001;
  localparam logic [SEED_W-1:0] SEED_MOD  = 22'h2AAAAB;
  localparam logic [6:0]        SEED_MUL  = 7'd125;
  localparam logic [SEED_W-1:0] SEED_ADD  = 22'd3;
  localparam int unsigned CRYPT_BANKS = 5;
  localparam int unsigned HASH_BANKS  = 3;
  localparam int unsigned BANK_DEPTH  = 256;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FOLD,
    S_DIV,
    S_PSET,
    S_PRD,
    S_PCHK,
    S_DONE
  } mpq_state_e;

  typedef struct packed {
    logic key_take;
    logic fold;
    logic div_start;
    logic div_step;
    logic probe_load;
    logic probe_adv;
    logic slot_wr;
    logic res_ok;
    logic res_fail;
  } mpq_cmd_t;

  typedef struct packed {
    logic init_done;
    logic key_zero;
    logic req_insert;
    logic div_last;
    logic slot_used;
    logic slot_match;
    logic probe_wrap;
  } mpq_sts_t;

endpackage

// ----- hw/rtl/mpq_req_if.sv -----
`timescale 1ns / 1ps
interface mpq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [mpq_pkg::KEY_W-1:0]  key_byte;
  modport source (output valid, req_type, key_byte, input ready);
  modport sink   (input valid, req_type, key_byte, output ready);
endinterface

// ----- hw/rtl/mpq_rsp_if.sv -----
`timescale 1ns / 1ps
interface mpq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       success;
  logic [mpq_pkg::POS_W-1:0]  position;
  modport source (output valid, success, position, input ready);
  modport sink   (input valid, success, position, output ready);
endinterface

// ----- hw/rtl/mpq_cfg_if.sv -----
`timescale 1ns / 1ps
interface mpq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mpq_pkg::TLEN_W-1:0]  table_length;
  modport source (output valid, table_length, input ready);
  modport sink   (input valid, table_length, output ready);
endinterface

// ----- hw/rtl/mpq_ram.sv -----
`timescale 1ns / 1ps
module mpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hw/rtl/mpq_ctrl.sv -----
`timescale 1ns / 1ps
module mpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  mpq_pkg::mpq_sts_t sts_i,
  output mpq_pkg::mpq_cmd_t cmd_o
);
  mpq_pkg::mpq_state_e state_q, state_d;
  logic req_xfer;

  assign req_xfer = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpq_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpq_pkg::S_INIT: if (sts_i.init_done) state_d = mpq_pkg::S_IDLE;
      mpq_pkg::S_IDLE: begin
        if (req_xfer) state_d = sts_i.key_zero ? mpq_pkg::S_DIV : mpq_pkg::S_FOLD;
      end
      mpq_pkg::S_FOLD: state_d = mpq_pkg::S_IDLE;
      mpq_pkg::S_DIV:  if (sts_i.div_last) state_d = mpq_pkg::S_PSET;
      mpq_pkg::S_PSET: state_d = mpq_pkg::S_PRD;
      mpq_pkg::S_PRD:  state_d = mpq_pkg::S_PCHK;
      mpq_pkg::S_PCHK: begin
        if (!sts_i.slot_used || sts_i.probe_wrap ||
            (sts_i.slot_match && !sts_i.req_insert)) begin
          state_d = mpq_pkg::S_DONE;
        end else begin
          state_d = mpq_pkg::S_PRD;
        end
      end
      mpq_pkg::S_DONE: if (rsp_ready_i) state_d = mpq_pkg::S_IDLE;
      default: state_d = mpq_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      mpq_pkg::S_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.key_take  = req_xfer;
        cmd_o.div_start = req_xfer && sts_i.key_zero;
      end
      mpq_pkg::S_FOLD: cmd_o.fold       = 1'b1;
      mpq_pkg::S_DIV:  cmd_o.div_step   = 1'b1;
      mpq_pkg::S_PSET: cmd_o.probe_load = 1'b1;
      mpq_pkg::S_PCHK: begin
        if (!sts_i.slot_used) begin
          cmd_o.slot_wr  = sts_i.req_insert;
          cmd_o.res_ok   = sts_i.req_insert;
          cmd_o.res_fail = !sts_i.req_insert;
        end else if (sts_i.slot_match && !sts_i.req_insert) begin
          cmd_o.res_ok = 1'b1;
        end else if (sts_i.probe_wrap) begin
          cmd_o.res_fail = 1'b1;
        end else begin
          cmd_o.probe_adv = 1'b1;
        end
      end
      mpq_pkg::S_DONE: rsp_valid_o = 1'b1;
      mpq_pkg::S_INIT, mpq_pkg::S_PRD: ;
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/mpq_dp.sv -----
`timescale 1ns / 1ps
module mpq_dp #(
  parameter int unsigned TABLE_SIZE = mpq_pkg::TABLE_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpq_pkg::mpq_cmd_t          cmd_i,
  output mpq_pkg::mpq_sts_t          sts_o,
  input  logic                       req_type_i,
  input  logic [mpq_pkg::KEY_W-1:0]  key_byte_i,
  input  logic [mpq_pkg::TLEN_W-1:0] table_length_i,
  output logic                       success_o,
  output logic [mpq_pkg::POS_W-1:0]  position_o
);
  localparam int unsigned PW = $clog2(TABLE_SIZE);
  localparam int unsigned LW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned SW = mpq_pkg::SEED_W;
  localparam int unsigned NB = mpq_pkg::HASH_BANKS;

  // ---------------- crypt table fill ----------------
  logic [SW-1:0] seed_q, acc_q;
  logic [2:0]    bit_q;
  logic          half_q, fill_done_q;
  logic [2:0]    k_q;
  logic [7:0]    lo_q;
  logic [15:0]   hi_q;
  logic [SW:0]   dbl, dbl_r, sum, sum_r, inc;
  logic [SW-1:0] acc_d, seed_nxt;
  logic          fill_wr;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, mpq_pkg::SEED_MOD}) ? dbl - {1'b0, mpq_pkg::SEED_MOD} : dbl;
    sum   = dbl_r + {1'b0, seed_q};
    sum_r = (sum >= {1'b0, mpq_pkg::SEED_MOD}) ? sum - {1'b0, mpq_pkg::SEED_MOD} : sum;
    acc_d = mpq_pkg::SEED_MUL[3'd6 - bit_q] ? sum_r[SW-1:0] : dbl_r[SW-1:0];
    inc   = {1'b0, acc_q} + {1'b0, mpq_pkg::SEED_ADD};
    seed_nxt = (inc >= {1'b0, mpq_pkg::SEED_MOD}) ?
               SW'(inc - {1'b0, mpq_pkg::SEED_MOD}) : inc[SW-1:0];
  end

  assign fill_wr = !fill_done_q && (bit_q == 3'd7) && half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mpq_pkg::SEED_INIT;
      acc_q       <= '0;
      bit_q       <= '0;
      half_q      <= 1'b0;
      k_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      fill_done_q <= 1'b0;
    end else if (!fill_done_q) begin
      if (bit_q != 3'd7) begin
        acc_q <= acc_d;
        bit_q <= bit_q + 3'd1;
      end else begin
        seed_q <= seed_nxt;
        acc_q  <= '0;
        bit_q  <= '0;
        half_q <= !half_q;
        if (!half_q) begin
          hi_q <= seed_nxt[15:0];
        end else if (k_q == 3'(mpq_pkg::CRYPT_BANKS - 1)) begin
          k_q <= '0;
          if (lo_q == 8'hFF) fill_done_q <= 1'b1;
          else lo_q <= lo_q + 8'd1;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
    end
  end

  // ---------------- slot store clearing ----------------
  logic [PW-1:0] clr_q;
  logic          clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_q == PW'(TABLE_SIZE - 1)) clr_done_q <= 1'b1;
      else clr_q <= clr_q + 1'b1;
    end
  end

  // ---------------- hashing ----------------
  logic [7:0]  ch_up, ch_q;
  logic [31:0] mix_q   [NB];
  logic [31:0] carry_q [NB];
  logic [31:0] crypt_rd [NB];
  logic [31:0] m_w     [NB];

  assign ch_up = (key_byte_i >= 8'h61 && key_byte_i <= 8'h7A) ? key_byte_i - 8'h20
                                                                : key_byte_i;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    mpq_ram #(.WIDTH(32), .DEPTH(mpq_pkg::BANK_DEPTH)) u_crypt (
      .clk_i   (clk_i),
      .we_i    (fill_wr && (k_q == 3'(b))),
      .waddr_i (lo_q),
      .wdata_i ({hi_q, seed_nxt[15:0]}),
      .raddr_i (ch_up),
      .rdata_o (crypt_rd[b])
    );

    assign m_w[b] = crypt_rd[b] ^ (mix_q[b] + carry_q[b]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mix_q[b]   <= mpq_pkg::MIX_INIT;
        carry_q[b] <= mpq_pkg::CARRY_INIT;
      end else if (cmd_i.res_ok || cmd_i.res_fail) begin
        mix_q[b]   <= mpq_pkg::MIX_INIT;
        carry_q[b] <= mpq_pkg::CARRY_INIT;
      end else if (cmd_i.fold) begin
        mix_q[b]   <= m_w[b];
        carry_q[b] <= {24'd0, ch_q} + m_w[b] + carry_q[b] + {carry_q[b][26:0], 5'd0} + 32'd3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_take) ch_q <= ch_up;
  end

  // ---------------- start slot: offset hash mod length ----------------
  logic [31:0]   len32;
  logic [LW-1:0] len_q, rem_q;
  logic [LW:0]   rem_sh;
  logic [31:0]   dvd_q;
  logic [4:0]    cnt_q;
  logic          req_q;

  always_comb begin
    len32 = {21'd0, table_length_i};
    if (len32 == 32'd0) len32 = 32'd1;
    else if (len32 > 32'(TABLE_SIZE)) len32 = 32'(TABLE_SIZE);
    rem_sh = {rem_q, dvd_q[31]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      len_q <= LW'(len32);
      dvd_q <= mix_q[0];
      rem_q <= '0;
      cnt_q <= '0;
      req_q <= req_type_i;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      cnt_q <= cnt_q + 5'd1;
      rem_q <= (rem_sh >= {1'b0, len_q}) ? LW'(rem_sh - {1'b0, len_q}) : LW'(rem_sh);
    end
  end

  // ---------------- probe ----------------
  logic [PW-1:0] pos_q, start_q, pos_nxt;
  logic [LW-1:0] pos_inc;
  logic [64:0]   slot_rd, slot_wd;
  logic          slot_we;
  logic [PW-1:0] slot_wa;

  assign pos_inc = LW'(pos_q) + 1'b1;
  assign pos_nxt = (pos_inc == len_q) ? '0 : PW'(pos_inc);

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_load) begin
      pos_q   <= PW'(rem_q);
      start_q <= PW'(rem_q);
    end else if (cmd_i.probe_adv) begin
      pos_q <= pos_nxt;
    end
  end

  assign slot_we = !clr_done_q || cmd_i.slot_wr;
  assign slot_wa = !clr_done_q ? clr_q : pos_q;
  assign slot_wd = !clr_done_q ? '0 : {1'b1, mix_q[1], mix_q[2]};

  mpq_ram #(.WIDTH(65), .DEPTH(TABLE_SIZE)) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_wa),
    .wdata_i (slot_wd),
    .raddr_i (pos_q),
    .rdata_o (slot_rd)
  );

  // ---------------- result ----------------
  logic                      res_ok_q;
  logic [mpq_pkg::POS_W-1:0] res_pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ok) begin
      res_ok_q  <= 1'b1;
      res_pos_q <= mpq_pkg::POS_W'(pos_q);
    end else if (cmd_i.res_fail) begin
      res_ok_q  <= 1'b0;
      res_pos_q <= '0;
    end
  end

  assign success_o  = res_ok_q;
  assign position_o = res_pos_q;

  assign sts_o.init_done  = fill_done_q && clr_done_q;
  assign sts_o.key_zero   = (key_byte_i == '0);
  assign sts_o.req_insert = (req_q == mpq_pkg::REQ_INSERT);
  assign sts_o.div_last   = (cnt_q == 5'd31);
  assign sts_o.slot_used  = slot_rd[64];
  assign sts_o.slot_match = (slot_rd[63:0] == {mix_q[1], mix_q[2]});
  assign sts_o.probe_wrap = (pos_nxt == start_q);
endmodule

// ----- hw/rtl/mpq_hash_table_engine_unit.sv -----
`timescale 1ns / 1ps
// A nonzero key byte is handled by a crypt bank read, then a fold of the three hashes.
// A zero byte runs the bit-serial remainder, loads the start slot, then reads and checks
// each probed slot in turn; the result is then held. A new key byte is taken only
// after its fold, a terminator only after its probe walk and result transfer. Reset:
// async, active low; no item is accepted until crypt fill and slot clearing finish.
module mpq_hash_table_engine_unit #(
  parameter int unsigned TABLE_SIZE = mpq_pkg::TABLE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o,
  mpq_cfg_if.sink   cfg_i
);
  // Table length reg; user must write only while idle (unenforced); always ready.
  logic [mpq_pkg::TLEN_W-1:0] tlen_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q <= mpq_pkg::TLEN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tlen_q <= cfg_i.table_length;
    end
  end

  mpq_pkg::mpq_cmd_t cmd;
  mpq_pkg::mpq_sts_t sts;

  // Sequencer: init wait, byte fold, remainder, probe loop, result hold.
  mpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hash registers, crypt banks, divider, slot store and result register.
  mpq_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .key_byte_i     (req_i.key_byte),
    .table_length_i (tlen_q),
    .success_o      (rsp_o.success),
    .position_o     (rsp_o.position)
  );
endmodule

// ----- hw/rtl/mpq_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpq_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      success_i,
  input logic [mpq_pkg::POS_W-1:0] position_i
);
  `MPQ_ASSERT_IMP(a_fail_pos_zero, clk_i, rst_ni, rsp_valid_i && !success_i, position_i == '0, "failed result with nonzero position")
  `MPQ_ASSERT_NXT(a_one_result, clk_i, rst_ni, rsp_valid_i && rsp_ready_i, !rsp_valid_i, "result repeated after transfer")
  `MPQ_ASSERT_IMP(a_no_take_pending, clk_i, rst_ni, rsp_valid_i, !req_ready_i, "input taken while result pending")
  `MPQ_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "no busy cycle after input transfer")
  `MPQ_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(success_i) && $stable(position_i), "stalled result changed")
endmodule

bind mpq_hash_table_engine_unit mpq_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .success_i   (rsp_o.success),
  .position_i  (rsp_o.position)
);
